@@ hdl/rcap_pkg.sv @@
`timescale 1ns / 1ps

package rcap_pkg;

    localparam int MAX_CELLS = 64;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int LEN_W     = CELL_W + 1;
    localparam int HOOD      = 5;
    localparam int DRAW_BITS = 31;
    localparam int GEN_W     = 48;
    localparam int MUL_BITS  = 35;

    localparam logic [MUL_BITS-1:0] GEN_MUL   = 35'h5_DEEC_E66D;
    localparam logic [GEN_W-1:0]    GEN_ADD   = 48'hB;
    localparam logic [15:0]         SEED_LOW  = 16'h330E;
    localparam logic [31:0]         RULE_INIT = 32'd1436965290;
    localparam logic [LEN_W-1:0]    LEN_INIT  = LEN_W'(MAX_CELLS);
    localparam logic [LEN_W-1:0]    LEN_MIN   = LEN_W'(HOOD);
    localparam logic [LEN_W-1:0]    LEN_MAX   = LEN_W'(MAX_CELLS);

    // Command codes
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_SEED  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_RULE = 1'b0;
    localparam logic CFG_LEN  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] step_count;
        logic [31:0] seed_value;
    } t_in_word;

    typedef struct packed {
        logic [MAX_CELLS-1:0] cell_pattern;
        logic                 seeded;
    } t_out_word;

    typedef struct packed {
        logic        load;
        logic        start;
        logic [31:0] seed;
    } t_lcg_req;

    typedef struct packed {
        logic                 done;
        logic [DRAW_BITS-1:0] draw;
    } t_lcg_rsp;

endpackage

@@ hdl/ring_cellular_automaton_prng.sv @@
`timescale 1ns / 1ps

// Radius-two cellular automaton random generator on a ring of up to 64 cells.
// The cells live in one rotating shift register and are updated one cell per
// cycle, and a step word runs all of its generations before the next word can
// be taken. Seeding runs the 48-bit generator through a bit-serial multiplier
// over the 35-bit multiplier constant, one draw per 31 cells, and fills the
// ring from the draws. Clear empties the ring and the unused code leaves it as
// it is; both go straight on to the result.
// A finished result waits in its own output register, so the next word is
// taken while the previous result is still stalled.

module ring_cellular_automaton_prng (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rcap_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rcap_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rcap_pkg::*;

    localparam logic [4:0] DRAW_LAST = 5'(DRAW_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEN,
        S_MUL,
        S_FILL,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [MAX_CELLS-1:0] r_cells;
    logic [31:0]          r_rule;
    logic [LEN_W-1:0]     r_len;
    logic                 r_seeded;
    logic [15:0]          r_gens;
    logic [CELL_W-1:0]    r_k;
    logic [4:0]           r_dcnt;
    logic [DRAW_BITS-1:0] r_v;
    logic                 r_m1;
    logic                 r_m2;
    logic                 r_w0;
    logic                 r_w1;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic [LEN_W-1:0]     w_len;
    logic [LEN_W-1:0]     w_len_m1;
    logic [LEN_W-1:0]     w_len_m2;
    logic [CELL_W-1:0]    w_last;
    logic [CELL_W-1:0]    w_pen;
    logic [MAX_CELLS-1:0] w_mask;
    logic [MAX_CELLS-1:0] w_shr;
    logic [MAX_CELLS-1:0] w_rot;
    logic                 w_p1;
    logic                 w_p2;
    logic [HOOD-1:0]      w_hood;
    logic                 w_new;
    logic                 w_ins;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_gen_end;
    t_lcg_req             w_lcg_req;
    t_lcg_rsp             w_lcg_rsp;

    always_comb begin
        if (r_len < LEN_MIN) begin
            w_len = LEN_MIN;
        end else if (r_len > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = r_len;
        end
    end

    assign w_len_m1 = w_len - LEN_W'(1);
    assign w_len_m2 = w_len - LEN_W'(2);
    assign w_last   = w_len_m1[CELL_W-1:0];
    assign w_pen    = w_len_m2[CELL_W-1:0];

    // Bit 0 of the register always holds the old value of the cell being
    // updated; the new value enters at the top of the ring.
    assign w_shr = {r_cells[MAX_CELLS-1], r_cells[MAX_CELLS-1:1]};

    always_comb begin
        for (int j = 0; j < MAX_CELLS; j++) begin
            w_mask[j] = (LEN_W'(j) < w_len);
            if (CELL_W'(j) == w_last) begin
                w_rot[j] = w_ins;
            end else if (CELL_W'(j) < w_last) begin
                w_rot[j] = w_shr[j];
            end else begin
                w_rot[j] = r_cells[j];
            end
        end
    end

    // Near the end of the ring the right-hand neighbours have already been
    // overwritten, so their old values come from the saved copies.
    always_comb begin
        if (r_k == w_last) begin
            w_p1 = r_w0;
            w_p2 = r_w1;
        end else if (r_k == w_pen) begin
            w_p1 = r_cells[1];
            w_p2 = r_w0;
        end else begin
            w_p1 = r_cells[1];
            w_p2 = r_cells[2];
        end
    end

    assign w_hood     = {w_p2, w_p1, r_cells[0], r_m1, r_m2};
    assign w_new      = r_rule[w_hood];
    assign w_ins      = (r_state == S_FILL) ? r_v[0] : w_new;
    assign w_gen_end  = (r_k == w_last);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_lcg_req.load  = w_in_acc && (i_in_word.command == CMD_SEED);
    assign w_lcg_req.seed  = i_in_word.seed_value;
    assign w_lcg_req.start = (r_state == S_FILL) && !w_gen_end && (r_dcnt == DRAW_LAST);

    rcap_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lcg_req),
        .o_rsp   (w_lcg_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cells     <= '0;
            r_rule      <= RULE_INIT;
            r_len       <= LEN_INIT;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_gens      <= '0;
            r_k         <= '0;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RULE: r_rule <= i_cfg_data;
                    CFG_LEN:  r_len  <= i_cfg_data[LEN_W-1:0];
                    default:  r_rule <= r_rule;
                endcase
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_k    <= '0;
                        r_dcnt <= '0;
                        r_m1   <= r_cells[w_last];
                        r_m2   <= r_cells[w_pen];
                        r_w0   <= r_cells[0];
                        r_w1   <= r_cells[1];
                        r_gens <= i_in_word.step_count;
                        case (i_in_word.command)
                            CMD_STEP: begin
                                if (i_in_word.step_count == 16'd0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_GEN;
                                end
                            end
                            CMD_SEED: begin
                                r_seeded <= 1'b1;
                                r_state  <= S_MUL;
                            end
                            CMD_CLEAR: begin
                                r_cells <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_GEN: begin
                    r_cells <= w_rot;
                    if (w_gen_end) begin
                        // Old values for the next generation are the new ones.
                        r_k    <= '0;
                        r_m1   <= w_new;
                        r_m2   <= r_cells[w_last];
                        r_w0   <= r_cells[1];
                        r_w1   <= r_cells[2];
                        r_gens <= r_gens - 16'd1;
                        if (r_gens == 16'd1) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_k  <= r_k + CELL_W'(1);
                        r_m1 <= r_cells[0];
                        r_m2 <= r_m1;
                    end
                end
                S_MUL: begin
                    if (w_lcg_rsp.done) begin
                        r_v     <= w_lcg_rsp.draw;
                        r_dcnt  <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_cells <= w_rot;
                    r_v     <= r_v >> 1;
                    r_dcnt  <= r_dcnt + 5'd1;
                    if (w_gen_end) begin
                        r_k     <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + CELL_W'(1);
                        if (r_dcnt == DRAW_LAST) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.cell_pattern <= r_cells & w_mask;
                        r_out.seeded       <= r_seeded;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ hdl/rcap_lcg.sv @@
`timescale 1ns / 1ps

module rcap_lcg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcap_pkg::t_lcg_req i_req,
    output rcap_pkg::t_lcg_rsp o_rsp
);
    import rcap_pkg::*;

    localparam logic [5:0] MUL_LAST = 6'(MUL_BITS - 1);

    logic [GEN_W-1:0] r_state;
    logic [GEN_W-1:0] r_acc;
    logic [GEN_W-1:0] r_shift;
    logic [5:0]       r_bit;
    logic             r_busy;
    logic             r_done;
    logic [GEN_W-1:0] w_acc_next;
    logic [GEN_W-1:0] w_seed_state;

    // Shift-and-add over the multiplier constant, one bit per cycle.
    assign w_acc_next   = GEN_MUL[r_bit] ? r_acc + r_shift : r_acc;
    assign w_seed_state = {i_req.seed, SEED_LOW};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_bit   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_busy && (r_bit == MUL_LAST);
            if (r_busy) begin
                r_acc   <= w_acc_next;
                r_shift <= r_shift << 1;
                r_bit   <= r_bit + 6'd1;
                if (r_bit == MUL_LAST) begin
                    r_state <= w_acc_next;
                    r_busy  <= 1'b0;
                end
            end else if (i_req.load) begin
                r_state <= w_seed_state;
                r_shift <= w_seed_state;
                r_acc   <= GEN_ADD;
                r_bit   <= '0;
                r_busy  <= 1'b1;
            end else if (i_req.start) begin
                r_shift <= r_state;
                r_acc   <= GEN_ADD;
                r_bit   <= '0;
                r_busy  <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.draw = r_state[GEN_W-1:GEN_W-DRAW_BITS];

endmodule

@@ hdl/rcap_checker.sv @@
`timescale 1ns / 1ps

module rcap_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rcap_pkg::t_out_word o_out_word
);
    logic r_seen_seed;

    // Remembers that some delivered word already reported a seeded generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_seed <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_word.seeded) begin
            r_seen_seed <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed or vanished");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the previous word was worked off");

    a_seeded_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_seed |-> o_out_word.seeded)
        else $error("seeded flag dropped after it had been reported");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word offered straight after reset");

endmodule

bind ring_cellular_automaton_prng rcap_checker u_rcap_checker (.*);

@@ test/ring_cellular_automaton_prng_tb.sv @@
`timescale 1ns / 1ps

module ring_cellular_automaton_prng_tb;
    import rcap_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 1_500_000;
    localparam int         PHASES      = 10;
    localparam int         PHASE_WORDS = 163;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in_word    word;
        bit          fixed;
        t_out_word   want;
        logic        reg_index;
        logic [31:0] reg_data;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = CFG_RULE;
    logic [31:0] i_cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;
    logic       o_cfg_ready;

    // Shadow of the automaton and its registers.
    logic [63:0] ca_cells  = '0;
    logic [47:0] ca_gen    = '0;
    logic        ca_seeded = 1'b0;
    logic [31:0] ca_rule   = RULE_INIT;
    logic [6:0]  ca_len    = LEN_INIT;

    t_out_word due_patterns[$];
    t_row      script[$];
    int        fault_count = 0;
    int        quiet_cycles = 0;
    int        stall_run = 0;
    bit        tx_gap_on = 1'b0;
    bit        rx_idle_on = 1'b0;
    t_out_word head;

    ring_cellular_automaton_prng uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_out_word ca_advance(input t_in_word w);
        t_out_word   r;
        int          n;
        logic [63:0] nxt;
        logic [30:0] v;
        logic [4:0]  hood;
        n = (ca_len < LEN_MIN) ? HOOD : (ca_len > LEN_MAX) ? MAX_CELLS : int'(ca_len);
        case (w.command)
            CMD_STEP: begin
                repeat (w.step_count) begin
                    nxt = ca_cells;
                    for (int i = 0; i < n; i++) begin
                        hood = {ca_cells[(i + 2) % n], ca_cells[(i + 1) % n], ca_cells[i],
                                ca_cells[(i + n - 1) % n], ca_cells[(i + n - 2) % n]};
                        nxt[i] = ca_rule[hood];
                    end
                    ca_cells = nxt;
                end
            end
            CMD_SEED: begin
                ca_gen = {w.seed_value, SEED_LOW};
                v = '0;
                for (int i = 0; i < n; i++) begin
                    if (i % DRAW_BITS == 0) begin
                        ca_gen = ca_gen * GEN_MUL + GEN_ADD;
                        v = ca_gen[47:17];
                    end
                    ca_cells[i] = v[0];
                    v = v >> 1;
                end
                ca_seeded = 1'b1;
            end
            CMD_CLEAR: begin
                ca_cells = '0;
            end
            default: begin
            end
        endcase
        r.cell_pattern = (n == 64) ? ca_cells : ca_cells & ((64'd1 << n) - 64'd1);
        r.seeded = ca_seeded;
        return r;
    endfunction

    function automatic void add_word(input logic [1:0] cmd, input logic [15:0] cnt,
                                     input logic [31:0] seed);
        t_row row;
        row.kind = ROW_WORD;
        row.word = {cmd, cnt, seed};
        row.fixed = 1'b0;
        row.want = '0;
        row.reg_index = CFG_RULE;
        row.reg_data = '0;
        script.push_back(row);
    endfunction

    function automatic void add_fixed(input logic [1:0] cmd, input logic [15:0] cnt,
                                      input logic [31:0] seed, input logic [63:0] pattern,
                                      input logic seeded);
        add_word(cmd, cnt, seed);
        script[$].fixed = 1'b1;
        script[$].want = {pattern, seeded};
    endfunction

    function automatic void add_reg(input logic idx, input logic [31:0] data);
        t_row row;
        row.kind = ROW_REG;
        row.word = '0;
        row.fixed = 1'b0;
        row.want = '0;
        row.reg_index = idx;
        row.reg_data = data;
        script.push_back(row);
    endfunction

    task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
        if (fault_count < 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
        fault_count++;
    endtask

    // Called at a rising edge; returns at the edge where the word is taken, or later when a random gap follows it.
    task automatic send_word(input t_in_word w, input bit fixed, input t_out_word want);
        t_out_word r;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        r = ca_advance(w);
        due_patterns.push_back(fixed ? want : r);
        if (tx_gap_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_patterns.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RULE: ca_rule = data;
            CFG_LEN:  ca_len = data[6:0];
            default: begin
            end
        endcase
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        pick = $urandom_range(0, 99);
        w.seed_value = $urandom();
        w.step_count = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(5, 40))
                                                    : 16'($urandom_range(0, 4));
        w.command = (pick < 55) ? CMD_STEP : (pick < 80) ? CMD_SEED :
                    (pick < 92) ? CMD_CLEAR : CMD_UNUSED;
        return w;
    endfunction

    // Bursts of stall on the result side while idling is enabled.
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run--;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            stall_run = $urandom_range(1, 8);
        end
        i_out_stall <= (stall_run > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_patterns.size() == 0) begin
                    note_fault("unexpected word", '0, o_out_word.cell_pattern);
                end else begin
                    head = due_patterns.pop_front();
                    if (o_out_word.cell_pattern !== head.cell_pattern) begin
                        note_fault("cell_pattern", head.cell_pattern, o_out_word.cell_pattern);
                    end
                    if (o_out_word.seeded !== head.seeded) begin
                        note_fault("seeded", 64'(head.seeded), 64'(o_out_word.seeded));
                    end
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ring_cellular_automaton_prng_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] rule;
        logic [6:0]  len;

        // Directed part: fresh state, edge lengths, draw boundaries and
        // cells outside the ring.
        add_fixed(CMD_STEP, 16'd0, 32'd0, 64'd0, 1'b0);
        add_fixed(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 64'd0, 1'b0);
        add_fixed(CMD_CLEAR, 16'd0, 32'd0, 64'd0, 1'b0);
        add_word(CMD_STEP, 16'd7, 32'd0);
        add_word(CMD_SEED, 16'd0, 32'd0);
        add_word(CMD_STEP, 16'd1, 32'd0);
        add_word(CMD_SEED, 16'd0, 32'hFFFF_FFFF);
        add_word(CMD_STEP, 16'd3, 32'd0);
        add_fixed(CMD_CLEAR, 16'd0, 32'd0, 64'd0, 1'b1);
        add_word(CMD_SEED, 16'd9, 32'h1234_5678);
        add_reg(CFG_LEN, 32'd0);
        add_word(CMD_SEED, 16'd0, 32'hA5A5_A5A5);
        add_word(CMD_STEP, 16'hFFFF, 32'd0);
        add_reg(CFG_LEN, 32'd4);
        add_word(CMD_STEP, 16'd2, 32'd0);
        add_reg(CFG_LEN, 32'd127);
        add_word(CMD_SEED, 16'd0, 32'h5A5A_5A5A);
        add_word(CMD_STEP, 16'd4, 32'd0);
        add_reg(CFG_RULE, 32'd0);
        add_fixed(CMD_STEP, 16'd1, 32'd0, 64'd0, 1'b1);
        add_reg(CFG_RULE, 32'hFFFF_FFFF);
        add_fixed(CMD_STEP, 16'd1, 32'd0, {64{1'b1}}, 1'b1);
        // Seeding a short ring must leave the upper cells set.
        add_reg(CFG_LEN, 32'd10);
        add_word(CMD_SEED, 16'd0, 32'h0000_0001);
        add_reg(CFG_LEN, 32'd64);
        add_word(CMD_STEP, 16'd0, 32'd0);
        add_reg(CFG_RULE, RULE_INIT);
        add_reg(CFG_LEN, 32'd31);
        add_word(CMD_SEED, 16'd0, 32'h3C96_0F01);
        add_reg(CFG_LEN, 32'd32);
        add_word(CMD_SEED, 16'd0, 32'h3C96_0F01);
        add_reg(CFG_LEN, 32'd62);
        add_word(CMD_SEED, 16'd0, 32'h8000_0000);
        add_reg(CFG_LEN, 32'd63);
        add_word(CMD_SEED, 16'd0, 32'h8000_0000);
        add_word(CMD_UNUSED, 16'd5, 32'h0F0F_0F0F);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_gap_on = 1'b1;
        rx_idle_on = 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_REG) begin
                write_reg(script[k].reg_index, script[k].reg_data);
            end else begin
                send_word(script[k].word, script[k].fixed, script[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            rule = $urandom();
            case (p)
                0:       begin rule = RULE_INIT; len = 7'd64; end
                1:       len = 7'd5;
                2:       len = 7'd0;
                3:       begin rule = 32'd0; len = 7'd37; end
                4:       begin rule = 32'hFFFF_FFFF; len = 7'd20; end
                5:       len = 7'd127;
                6:       len = 7'd31;
                7:       len = 7'd32;
                8:       len = 7'($urandom_range(5, 64));
                default: len = 7'd63;
            endcase
            write_reg(CFG_RULE, rule);
            // The upper bits of a length word are junk and must be ignored.
            write_reg(CFG_LEN, ($urandom() & ~32'h7F) | 32'(len));
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // Every fourth run of 32 words goes without idling, as does
                // the whole of the last phase.
                tx_gap_on = (p != PHASES - 1) && ((k / 32) % 4 != 3);
                rx_idle_on = tx_gap_on;
                if ($urandom_range(0, 119) == 0) begin
                    drain();
                end
                send_word(random_word(), 1'b0, '0);
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        fault_count += due_patterns.size();
        if (fault_count == 0) begin
            $display("ring_cellular_automaton_prng_tb: clean");
        end else begin
            $display("ring_cellular_automaton_prng_tb: errors");
        end
        $finish;
    end

endmodule
